### rtl/core/twodom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodom_pkg
// Shared types, constants and saturation helpers of the tracking wheel
// odometry core.
// ----------------------------------------------------------------------------
package twodom_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 24;
   localparam int unsigned CNT_W            = 5;

   typedef enum logic [2:0] {
      SH_0,
      SH_1,
      SH_8,
      SH_24,
      SH_29,
      SH_30
   } shift_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } md_op_type;

   typedef struct packed {
      logic              start;
      md_op_type         op;
      shift_type         sh;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] res;
   } md_rsp_type;

   typedef struct packed {
      logic              done;
      logic signed [33:0] sin;
      logic signed [33:0] cos;
   } cd_rsp_type;

   localparam logic [2:0] REG_WHEEL_SCALE    = 3'd0;
   localparam logic [2:0] REG_TRACKING_SCALE = 3'd1;
   localparam logic [2:0] REG_BASE_WIDTH     = 3'd2;
   localparam logic [2:0] REG_TRACKING_OFS   = 3'd3;
   localparam logic [2:0] REG_START_X        = 3'd4;
   localparam logic [2:0] REG_START_Y        = 3'd5;
   localparam logic [2:0] REG_START_ANGLE    = 3'd6;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   localparam logic signed [39:0] Q30_PI      = 40'sd3373259426;
   localparam logic signed [39:0] Q30_HALF_PI = 40'sd1686629713;
   localparam logic signed [39:0] Q30_TWO_PI  = 40'sd6746518852;
   localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
      32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
      32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
      32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048,
      32'd1024, 32'd512, 32'd256, 32'd128,
      32'd64, 32'd32, 32'd16, 32'd8,
      32'd4, 32'd2, 32'd1, 32'd0
   };

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // symmetric saturation at +-(2^63-1)
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64:63] == 2'b01) begin
         return S64_MAX;
      end else if (s[64:63] == 2'b10) begin
         return -S64_MAX;
      end else if (s[63:0] == 64'h8000_0000_0000_0000) begin
         return -S64_MAX;
      end else begin
         return s[63:0];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

### rtl/core/tracking_wheel_odometry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracking_wheel_odometry_core
// Pose update from five encoder counts per sample: heading from the left /
// right difference, arc chord from the shift, rotation to the field frame.
//
//   channel  direction  contents
//   req_     in         one sample of five encoder counts
//   rsp_     out        pose x, pose y, heading
//   csr_     in         register index and write data
//
// A sample with a heading change takes longer than one on a straight move;
// the one-bit-per-cycle divider dominates, next to the multiplies and the
// CORDIC_STEPS rotation steps plus range reduction per sine / cosine.
// req_tready is high only while no sample is in work; a result waiting on
// rsp_tready holds the next pose update. Synchronous reset clears pose,
// heading and the last counts and loads the register defaults.
// ----------------------------------------------------------------------------
module tracking_wheel_odometry_core
   import twodom_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // left_front_count, left_rear_count, right_front_count, right_rear_count,
   // back_count
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pose_x, pose_y, heading
   output logic [95:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   typedef enum logic [16:0] {
      ST_IDLE = 17'b00000000000000001,
      ST_DIFF = 17'b00000000000000010,
      ST_ANG  = 17'b00000000000000100,
      ST_DR   = 17'b00000000000001000,
      ST_DB   = 17'b00000000000010000,
      ST_TO   = 17'b00000000000100000,
      ST_CA   = 17'b00000000001000000,
      ST_QB   = 17'b00000000010000000,
      ST_LX   = 17'b00000000100000000,
      ST_QR   = 17'b00000001000000000,
      ST_LY   = 17'b00000010000000000,
      ST_CM   = 17'b00000100000000000,
      ST_G1   = 17'b00001000000000000,
      ST_G2   = 17'b00010000000000000,
      ST_G3   = 17'b00100000000000000,
      ST_G4   = 17'b01000000000000000,
      ST_POS  = 17'b10000000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic               issued_ff, issued_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        ws_ff, ws_in;
   logic [31:0]        ts_ff, ts_in;
   logic [30:0]        bw_ff, bw_in;
   logic signed [31:0] to_ff, to_in;
   logic signed [31:0] sa_ff, sa_in;
   logic signed [31:0] pos_x_ff, pos_x_in;
   logic signed [31:0] pos_y_ff, pos_y_in;
   logic signed [31:0] head_ff, head_in;
   logic signed [32:0] last_r_ff, last_r_in;
   logic signed [31:0] last_b_ff, last_b_in;
   logic signed [32:0] sum_l_ff, sum_l_in;
   logic signed [32:0] sum_r_ff, sum_r_in;
   logic signed [31:0] back_ff, back_in;
   logic signed [31:0] new_a_ff, new_a_in;
   logic signed [32:0] d_a_ff, d_a_in;
   logic signed [63:0] d_r_ff, d_r_in;
   logic signed [63:0] d_b_ff, d_b_in;
   logic signed [63:0] tmp_ff, tmp_in;
   logic signed [63:0] lx_ff, lx_in;
   logic signed [63:0] ly_ff, ly_in;
   logic signed [63:0] gx_ff, gx_in;
   logic signed [63:0] gy_ff, gy_in;
   logic signed [33:0] sin_ff, sin_in;
   logic signed [33:0] sm_ff, sm_in;
   logic signed [33:0] cm_ff, cm_in;

   md_req_type         md_req;
   md_rsp_type         md_rsp;
   cd_rsp_type         cd_rsp;
   logic               cd_start;
   logic signed [32:0] cd_angle;

   logic [30:0]        bw_eff;
   logic [33:0]        dl, dr;
   logic [32:0]        db;
   logic signed [31:0] new_a_calc;
   logic signed [32:0] d_a_calc;
   logic signed [63:0] db_adj;

   twodom_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   twodom_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cd_start),
      .angle (cd_angle),
      .rsp   (cd_rsp)
   );

   always_comb begin
      bw_eff     = (bw_ff == '0) ? 31'd1 : bw_ff;
      dl         = {sum_l_ff[32], sum_l_ff} - {sum_r_ff[32], sum_r_ff};
      dr         = {sum_r_ff[32], sum_r_ff} - {last_r_ff[32], last_r_ff};
      db         = {back_ff[31], back_ff} - {last_b_ff[31], last_b_ff};
      new_a_calc = sat32({{34{sa_ff[31]}}, sa_ff} + {{2{md_rsp.res[63]}}, md_rsp.res});
      d_a_calc   = {new_a_calc[31], new_a_calc} - {head_ff[31], head_ff};
      db_adj     = sat_add(d_b_ff, -md_rsp.res);

      md_req    = '0;
      md_req.op = OP_MUL;
      md_req.sh = SH_0;
      cd_start  = 1'b0;
      cd_angle  = '0;

      unique case (state_ff)
         ST_DIFF: begin
            md_req.a  = {{30{dl[33]}}, dl};
            md_req.b  = {32'b0, ws_ff};
            md_req.sh = SH_1;
         end
         ST_ANG: begin
            md_req.op = OP_DIV;
            md_req.a  = tmp_ff;
            md_req.b  = {33'b0, bw_eff};
            md_req.sh = SH_8;
         end
         ST_DR: begin
            md_req.a  = {{30{dr[33]}}, dr};
            md_req.b  = {32'b0, ws_ff};
            md_req.sh = SH_1;
         end
         ST_DB: begin
            md_req.a = {{31{db[32]}}, db};
            md_req.b = {32'b0, ts_ff};
         end
         ST_TO: begin
            md_req.a  = {{32{to_ff[31]}}, to_ff};
            md_req.b  = {{31{d_a_ff[32]}}, d_a_ff};
            md_req.sh = SH_8;
         end
         ST_QB: begin
            md_req.op = OP_DIV;
            md_req.a  = d_b_ff;
            md_req.b  = {{31{d_a_ff[32]}}, d_a_ff};
            md_req.sh = SH_24;
         end
         ST_QR: begin
            md_req.op = OP_DIV;
            md_req.a  = d_r_ff;
            md_req.b  = {{31{d_a_ff[32]}}, d_a_ff};
            md_req.sh = SH_24;
         end
         ST_LX, ST_LY: begin
            md_req.a  = tmp_ff;
            md_req.b  = {{30{sin_ff[33]}}, sin_ff};
            md_req.sh = SH_29;
         end
         ST_G1: begin
            md_req.a  = ly_ff;
            md_req.b  = {{30{cm_ff[33]}}, cm_ff};
            md_req.sh = SH_30;
         end
         ST_G2: begin
            md_req.a  = lx_ff;
            md_req.b  = {{30{sm_ff[33]}}, sm_ff};
            md_req.sh = SH_30;
         end
         ST_G3: begin
            md_req.a  = ly_ff;
            md_req.b  = {{30{sm_ff[33]}}, sm_ff};
            md_req.sh = SH_30;
         end
         ST_G4: begin
            md_req.a  = lx_ff;
            md_req.b  = {{30{cm_ff[33]}}, cm_ff};
            md_req.sh = SH_30;
         end
         ST_CA: begin
            cd_angle = d_a_ff;
            cd_start = !issued_ff;
         end
         ST_CM: begin
            cd_angle = {head_ff[31], head_ff} + {new_a_ff[31], new_a_ff};
            cd_start = !issued_ff;
         end
         default: begin
            md_req.a = '0;
         end
      endcase

      md_req.start = !issued_ff && (state_ff != ST_IDLE) && (state_ff != ST_POS)
                     && (state_ff != ST_CA) && (state_ff != ST_CM);
   end

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff;
      ws_in        = ws_ff;
      ts_in        = ts_ff;
      bw_in        = bw_ff;
      to_in        = to_ff;
      sa_in        = sa_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      last_r_in    = last_r_ff;
      last_b_in    = last_b_ff;
      sum_l_in     = sum_l_ff;
      sum_r_in     = sum_r_ff;
      back_in      = back_ff;
      new_a_in     = new_a_ff;
      d_a_in       = d_a_ff;
      d_r_in       = d_r_ff;
      d_b_in       = d_b_ff;
      tmp_in       = tmp_ff;
      lx_in        = lx_ff;
      ly_in        = ly_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      sin_in       = sin_ff;
      sm_in        = sm_ff;
      cm_in        = cm_ff;

      if (md_req.start || cd_start) begin
         issued_in = 1'b1;
      end
      if (md_rsp.done || cd_rsp.done) begin
         issued_in = 1'b0;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            REG_WHEEL_SCALE:    ws_in = csr_data;
            REG_TRACKING_SCALE: ts_in = csr_data;
            REG_BASE_WIDTH:     bw_in = csr_data[30:0];
            REG_TRACKING_OFS:   to_in = csr_data;
            REG_START_X:        pos_x_in = csr_data;
            REG_START_Y:        pos_y_in = csr_data;
            REG_START_ANGLE: begin
               sa_in   = csr_data;
               head_in = csr_data;
            end
            default: begin
               ws_in = ws_ff;
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sum_l_in = {req_tdata[31], req_tdata[31:0]}
                          + {req_tdata[63], req_tdata[63:32]};
               sum_r_in = {req_tdata[95], req_tdata[95:64]}
                          + {req_tdata[127], req_tdata[127:96]};
               back_in  = req_tdata[159:128];
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (md_rsp.done) begin
               tmp_in   = md_rsp.res;
               state_in = ST_ANG;
            end
         end
         ST_ANG: begin
            if (md_rsp.done) begin
               new_a_in = new_a_calc;
               d_a_in   = d_a_calc;
               state_in = ST_DR;
            end
         end
         ST_DR: begin
            if (md_rsp.done) begin
               d_r_in   = md_rsp.res;
               state_in = ST_DB;
            end
         end
         ST_DB: begin
            if (md_rsp.done) begin
               d_b_in   = md_rsp.res;
               state_in = ST_TO;
            end
         end
         ST_TO: begin
            if (md_rsp.done) begin
               d_b_in = db_adj;
               if (d_a_ff == '0) begin
                  lx_in    = db_adj;
                  ly_in    = d_r_ff;
                  state_in = ST_CM;
               end else begin
                  state_in = ST_CA;
               end
            end
         end
         ST_CA: begin
            if (cd_rsp.done) begin
               sin_in   = cd_rsp.sin;
               state_in = ST_QB;
            end
         end
         ST_QB: begin
            if (md_rsp.done) begin
               tmp_in   = sat_add(md_rsp.res, {{16{to_ff[31]}}, to_ff, 16'b0});
               state_in = ST_LX;
            end
         end
         ST_LX: begin
            if (md_rsp.done) begin
               lx_in    = md_rsp.res;
               state_in = ST_QR;
            end
         end
         ST_QR: begin
            if (md_rsp.done) begin
               tmp_in   = sat_add(md_rsp.res, {18'b0, bw_eff, 15'b0});
               state_in = ST_LY;
            end
         end
         ST_LY: begin
            if (md_rsp.done) begin
               ly_in    = md_rsp.res;
               state_in = ST_CM;
            end
         end
         ST_CM: begin
            if (cd_rsp.done) begin
               sm_in    = cd_rsp.sin;
               cm_in    = cd_rsp.cos;
               state_in = ST_G1;
            end
         end
         ST_G1: begin
            if (md_rsp.done) begin
               tmp_in   = md_rsp.res;
               state_in = ST_G2;
            end
         end
         ST_G2: begin
            if (md_rsp.done) begin
               gx_in    = sat_add(tmp_ff, md_rsp.res);
               state_in = ST_G3;
            end
         end
         ST_G3: begin
            if (md_rsp.done) begin
               tmp_in   = md_rsp.res;
               state_in = ST_G4;
            end
         end
         ST_G4: begin
            if (md_rsp.done) begin
               gy_in    = sat_add(tmp_ff, -md_rsp.res);
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            if (!rsp_valid_ff || rsp_tready) begin
               pos_x_in     = sat32({{34{pos_x_ff[31]}}, pos_x_ff}
                                    - {{18{gx_ff[63]}}, gx_ff[63:16]});
               pos_y_in     = sat32({{34{pos_y_ff[31]}}, pos_y_ff}
                                    + {{18{gy_ff[63]}}, gy_ff[63:16]});
               head_in      = new_a_ff;
               last_r_in    = sum_r_ff;
               last_b_in    = back_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ws_ff        <= '0;
         ts_ff        <= '0;
         bw_ff        <= 31'd65536;
         to_ff        <= '0;
         sa_ff        <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
         last_r_ff    <= '0;
         last_b_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         ws_ff        <= ws_in;
         ts_ff        <= ts_in;
         bw_ff        <= bw_in;
         to_ff        <= to_in;
         sa_ff        <= sa_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
         last_r_ff    <= last_r_in;
         last_b_ff    <= last_b_in;
      end
      sum_l_ff <= sum_l_in;
      sum_r_ff <= sum_r_in;
      back_ff  <= back_in;
      new_a_ff <= new_a_in;
      d_a_ff   <= d_a_in;
      d_r_ff   <= d_r_in;
      d_b_ff   <= d_b_in;
      tmp_ff   <= tmp_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      sin_ff   <= sin_in;
      sm_ff    <= sm_in;
      cm_ff    <= cm_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {head_ff, pos_y_ff, pos_x_ff};
   assign csr_ready  = 1'b1;

`ifndef SYNTHESIS
   a_rsp_from_pos: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_POS))
      else $error("result beat raised outside pose update");

   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      (md_rsp.done || cd_rsp.done) |-> issued_ff)
      else $error("unit done without an issued operation");

   a_state_advanced: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (last_r_ff == sum_r_ff && head_ff == new_a_ff))
      else $error("odometry state not advanced with result");
`endif

endmodule

### rtl/core/twodom_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodom_muldiv
// Shared multiply / divide unit: sign-magnitude 64x64 multiply from four
// 32x32 partial products, restoring divide one quotient bit per cycle,
// result shifted and saturated to +-(2^63-1).
// ----------------------------------------------------------------------------
module twodom_muldiv
   import twodom_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type req,
   output md_rsp_type rsp
);

   localparam int unsigned DIV_BITS = 88;
   localparam int unsigned CNT_BITS = $clog2(DIV_BITS);
   localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(4);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DIV_BITS - 1);

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_MUL  = 4'b0010,
      U_DIV  = 4'b0100,
      U_FIN  = 4'b1000
   } ustate_type;

   ustate_type          state_ff, state_in;
   md_op_type           op_ff, op_in;
   shift_type           sh_ff, sh_in;
   logic                neg_ff, neg_in;
   logic [63:0]         ma_ff, ma_in;
   logic [63:0]         mb_ff, mb_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [63:0]         prod_ff, prod_in;
   logic [127:0]        acc_ff, acc_in;
   logic [DIV_BITS-1:0] num_ff, num_in;
   logic [63:0]         rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic                done_ff, done_in;
   logic signed [63:0]  res_ff, res_in;

   logic [31:0]  a_part, b_part;
   logic [127:0] term;
   logic [64:0]  rem_sh, rem_sub;
   logic         fits;
   logic [63:0]  ma_new;
   logic [127:0] m_wide;
   logic [62:0]  m_sat;

   always_comb begin
      a_part  = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      b_part  = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      prod_in = a_part * b_part;
      rem_sh  = {rem_ff, num_ff[DIV_BITS-1]};
      rem_sub = rem_sh - {1'b0, mb_ff};
      fits    = rem_sh >= {1'b0, mb_ff};
      ma_new  = mag64(req.a);

      unique case (cnt_ff[2:0])
         3'd1:    term = {64'b0, prod_ff};
         3'd2,
         3'd3:    term = {32'b0, prod_ff, 32'b0};
         3'd4:    term = {prod_ff, 64'b0};
         default: term = '0;
      endcase

      if (op_ff == OP_DIV) begin
         m_wide = {40'b0, quo_ff};
      end else begin
         unique case (sh_ff)
            SH_0:    m_wide = acc_ff;
            SH_1:    m_wide = acc_ff >> 1;
            SH_8:    m_wide = acc_ff >> 8;
            SH_24:   m_wide = acc_ff >> 24;
            SH_29:   m_wide = acc_ff >> 29;
            SH_30:   m_wide = acc_ff >> 30;
            default: m_wide = acc_ff;
         endcase
      end
      m_sat = (|m_wide[127:63]) ? S64_MAX[62:0] : m_wide[62:0];

      state_in = state_ff;
      op_in    = op_ff;
      sh_in    = sh_ff;
      neg_in   = neg_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      res_in   = res_ff;

      unique case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               op_in  = req.op;
               sh_in  = req.sh;
               neg_in = req.a[63] ^ req.b[63];
               ma_in  = ma_new;
               mb_in  = mag64(req.b);
               cnt_in = '0;
               acc_in = '0;
               rem_in = '0;
               quo_in = '0;
               unique case (req.sh)
                  SH_8:    num_in = {16'b0, ma_new, 8'b0};
                  SH_24:   num_in = {ma_new, 24'b0};
                  default: num_in = {24'b0, ma_new};
               endcase
               state_in = (req.op == OP_DIV) ? U_DIV : U_MUL;
            end
         end
         U_MUL: begin
            acc_in = acc_ff + term;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = U_FIN;
            end
         end
         U_DIV: begin
            rem_in = fits ? rem_sub[63:0] : rem_sh[63:0];
            num_in = {num_ff[DIV_BITS-2:0], 1'b0};
            quo_in = {quo_ff[DIV_BITS-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            res_in   = neg_ff ? -$signed({1'b0, m_sat}) : $signed({1'b0, m_sat});
            done_in  = 1'b1;
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff   <= op_in;
      sh_ff   <= sh_in;
      neg_ff  <= neg_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule

### rtl/core/twodom_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twodom_cordic
// Sine and cosine in Q4.30 from a Q.25 angle: range reduction by 2pi steps,
// fold into [-pi/2, pi/2], then one rotation step per cycle.
// ----------------------------------------------------------------------------
module twodom_cordic
   import twodom_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] angle,
   output cd_rsp_type         rsp
);

   localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_RED  = 3'b010,
      C_ITER = 3'b100
   } cstate_type;

   cstate_type         state_ff, state_in;
   logic signed [39:0] r_ff, r_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;

   logic signed [33:0] dx, dy, at;

   always_comb begin
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      at = $signed({2'b0, ATAN_Q30[cnt_ff]});

      state_in = state_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               r_in     = {{2{angle[32]}}, angle, 5'b0};
               state_in = C_RED;
            end
         end
         C_RED: begin
            priority if (r_ff > Q30_PI) begin
               r_in = r_ff - Q30_TWO_PI;
            end else if (r_ff < -Q30_PI) begin
               r_in = r_ff + Q30_TWO_PI;
            end else begin
               priority if (r_ff > Q30_HALF_PI) begin
                  z_in   = 34'(Q30_PI - r_ff);
                  neg_in = 1'b1;
               end else if (r_ff < -Q30_HALF_PI) begin
                  z_in   = 34'(-Q30_PI - r_ff);
                  neg_in = 1'b1;
               end else begin
                  z_in   = 34'(r_ff);
                  neg_in = 1'b0;
               end
               x_in     = Q30_GAIN;
               y_in     = '0;
               cnt_in   = '0;
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (!z_ff[33]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      r_ff   <= r_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.sin  = y_ff;
   assign rsp.cos  = neg_ff ? -x_ff : x_ff;

endmodule
